>>> design/pced_pkg.sv
// ----------------------------------------------------------------------------
// pced_pkg
// shared types and constants for the potts copy energy delta block
// ----------------------------------------------------------------------------
package pced_pkg;

  localparam int IdW    = 16;
  localparam int TypeW  = 2;
  localparam int AreaW  = 16;
  localparam int PerimW = 16;
  localparam int AdhW   = 14;
  localparam int CntW   = 5;
  localparam int OutW   = 48;

  localparam logic [AdhW-1:0] ADH_MAX = '1;
  localparam logic [CntW-1:0] CNT_MAX = '1;

  localparam logic OP_HEADER   = 1'b0;
  localparam logic OP_NEIGHBOR = 1'b1;

  localparam int AddrW = 6;
  localparam int DataW = 64;

  localparam logic [2:0] REG_ADH_LO     = 3'd0;
  localparam logic [2:0] REG_ADH_HI     = 3'd1;
  localparam logic [2:0] REG_AREA_W     = 3'd2;
  localparam logic [2:0] REG_AREA_GOAL  = 3'd3;
  localparam logic [2:0] REG_PERIM_W    = 3'd4;
  localparam logic [2:0] REG_PERIM_GOAL = 3'd5;
  localparam logic [2:0] REG_PERIM_ON   = 3'd6;

  typedef struct packed {
    logic [63:0] adh_lo;
    logic [63:0] adh_hi;
    logic [31:0] area_w;
    logic [63:0] area_goal;
    logic [63:0] perim_w;
    logic [63:0] perim_goal;
    logic        perim_on;
  } cfg_t;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [TypeW-1:0]  ctype;
    logic [AreaW-1:0]  area;
    logic [PerimW-1:0] perim;
  } cell_t;

  typedef struct packed {
    cell_t           src;
    cell_t           tgt;
    logic [AdhW-1:0] adh_after;
    logic [AdhW-1:0] adh_before;
    logic [CntW-1:0] src_same;
    logic [CntW-1:0] src_diff;
    logic [CntW-1:0] tgt_same;
    logic [CntW-1:0] tgt_diff;
  } job_t;

endpackage

>>> design/pced_front.sv
// ----------------------------------------------------------------------------
// pced_front
// takes header and neighbor words, holds the cells, accumulates adhesion
// sums and neighbor counts, and posts a finished attempt to the job queue
// ----------------------------------------------------------------------------
module pced_front #(
  parameter int TYPES = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_op,
  input  logic [pced_pkg::IdW-1:0]     in_source_id,
  input  logic [pced_pkg::TypeW-1:0]   in_source_type,
  input  logic [pced_pkg::AreaW-1:0]   in_source_area,
  input  logic [pced_pkg::PerimW-1:0]  in_source_perimeter,
  input  logic [pced_pkg::IdW-1:0]     in_target_id,
  input  logic [pced_pkg::TypeW-1:0]   in_target_type,
  input  logic [pced_pkg::AreaW-1:0]   in_target_area,
  input  logic [pced_pkg::PerimW-1:0]  in_target_perimeter,
  input  logic [pced_pkg::IdW-1:0]     in_neighbor_id,
  input  logic [pced_pkg::TypeW-1:0]   in_neighbor_type,
  input  logic                         in_last_neighbor,
  input  logic [63:0]                  adh_lo,
  input  logic [63:0]                  adh_hi,
  input  logic                         q_full,
  output logic                         q_push,
  output pced_pkg::job_t               q_job
);

  pced_pkg::cell_t                src_r, src_nxt;
  pced_pkg::cell_t                tgt_r, tgt_nxt;
  logic [pced_pkg::AdhW-1:0]      before_r, before_nxt, before_sum;
  logic [pced_pkg::AdhW-1:0]      after_r, after_nxt, after_sum;
  logic [pced_pkg::CntW-1:0]      src_same_r, src_same_nxt, src_same_sum;
  logic [pced_pkg::CntW-1:0]      src_diff_r, src_diff_nxt, src_diff_sum;
  logic [pced_pkg::CntW-1:0]      tgt_same_r, tgt_same_nxt, tgt_same_sum;
  logic [pced_pkg::CntW-1:0]      tgt_diff_r, tgt_diff_nxt, tgt_diff_sum;
  logic                           accept;
  logic                           hit_src;
  logic                           hit_tgt;

  function automatic logic [7:0] adh_entry(input logic [127:0] rows,
                                           input logic [1:0] ntype,
                                           input logic [1:0] ctype);
    logic [3:0] k;
    k = 4'(int'(ntype) * TYPES + int'(ctype));
    return rows[8*k +: 8];
  endfunction

  function automatic logic [pced_pkg::AdhW-1:0] sat_add(input logic [pced_pkg::AdhW-1:0] a,
                                                         input logic [7:0] v);
    logic [pced_pkg::AdhW:0] s;
    s = {1'b0, a} + {{(pced_pkg::AdhW-7){1'b0}}, v};
    return s[pced_pkg::AdhW] ? pced_pkg::ADH_MAX : s[pced_pkg::AdhW-1:0];
  endfunction

  function automatic logic [pced_pkg::CntW-1:0] sat_inc(input logic [pced_pkg::CntW-1:0] c,
                                                         input logic en);
    return (en && c != pced_pkg::CNT_MAX) ? c + 1'b1 : c;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign hit_src  = in_neighbor_id == src_r.id;
  assign hit_tgt  = in_neighbor_id == tgt_r.id;

  always_comb begin
    before_sum   = hit_tgt ? before_r
                 : sat_add(before_r, adh_entry({adh_hi, adh_lo}, in_neighbor_type, tgt_r.ctype));
    after_sum    = hit_src ? after_r
                 : sat_add(after_r, adh_entry({adh_hi, adh_lo}, in_neighbor_type, src_r.ctype));
    src_same_sum = sat_inc(src_same_r, hit_src);
    src_diff_sum = sat_inc(src_diff_r, !hit_src);
    tgt_same_sum = sat_inc(tgt_same_r, hit_tgt);
    tgt_diff_sum = sat_inc(tgt_diff_r, !hit_tgt);
  end

  always_comb begin
    src_nxt      = src_r;
    tgt_nxt      = tgt_r;
    before_nxt   = before_r;
    after_nxt    = after_r;
    src_same_nxt = src_same_r;
    src_diff_nxt = src_diff_r;
    tgt_same_nxt = tgt_same_r;
    tgt_diff_nxt = tgt_diff_r;
    q_push       = 1'b0;
    if (accept) begin
      unique case (in_op)
        pced_pkg::OP_HEADER: begin
          src_nxt      = '{in_source_id, in_source_type, in_source_area, in_source_perimeter};
          tgt_nxt      = '{in_target_id, in_target_type, in_target_area, in_target_perimeter};
          before_nxt   = '0;
          after_nxt    = '0;
          src_same_nxt = '0;
          src_diff_nxt = '0;
          tgt_same_nxt = '0;
          tgt_diff_nxt = '0;
        end
        pced_pkg::OP_NEIGHBOR: begin
          if (in_last_neighbor) begin
            q_push       = 1'b1;
            before_nxt   = '0;
            after_nxt    = '0;
            src_same_nxt = '0;
            src_diff_nxt = '0;
            tgt_same_nxt = '0;
            tgt_diff_nxt = '0;
          end else begin
            before_nxt   = before_sum;
            after_nxt    = after_sum;
            src_same_nxt = src_same_sum;
            src_diff_nxt = src_diff_sum;
            tgt_same_nxt = tgt_same_sum;
            tgt_diff_nxt = tgt_diff_sum;
          end
        end
        default: ;
      endcase
    end
  end

  assign q_job = '{src_r, tgt_r, after_sum, before_sum,
                   src_same_sum, src_diff_sum, tgt_same_sum, tgt_diff_sum};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r      <= '0;
      tgt_r      <= '0;
      before_r   <= '0;
      after_r    <= '0;
      src_same_r <= '0;
      src_diff_r <= '0;
      tgt_same_r <= '0;
      tgt_diff_r <= '0;
    end else begin
      src_r      <= src_nxt;
      tgt_r      <= tgt_nxt;
      before_r   <= before_nxt;
      after_r    <= after_nxt;
      src_same_r <= src_same_nxt;
      src_diff_r <= src_diff_nxt;
      tgt_same_r <= tgt_same_nxt;
      tgt_diff_r <= tgt_diff_nxt;
    end
  end

endmodule

>>> design/pced_queue.sv
// ----------------------------------------------------------------------------
// pced_queue
// two-entry job queue between the front and the back
// ----------------------------------------------------------------------------
module pced_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pced_pkg::job_t  wr_job,
  input  logic            pop,
  output pced_pkg::job_t  rd_job,
  output logic            full,
  output logic            empty
);

  pced_pkg::job_t  mem_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> design/pced_back.sv
// ----------------------------------------------------------------------------
// pced_back
// sequences the area and perimeter quadratic terms through one shared
// multiplier pair and holds the result word for the output channel
// ----------------------------------------------------------------------------
module pced_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pced_pkg::cfg_t                 cfg,
  input  pced_pkg::job_t                 q_job,
  input  logic                           q_empty,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [pced_pkg::OutW-1:0] out_energy_delta
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PROD = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam logic [1:0] K_SRC_AREA  = 2'd0;
  localparam logic [1:0] K_TGT_AREA  = 2'd1;
  localparam logic [1:0] K_SRC_PERIM = 2'd2;
  localparam logic [1:0] K_TGT_PERIM = 2'd3;

  logic [1:0]                       state_r, state_nxt;
  logic [1:0]                       k_r, k_nxt;
  pced_pkg::job_t                   job_r, job_nxt;
  logic signed [pced_pkg::OutW-1:0] acc_r, acc_nxt;
  logic signed [24:0]               prod_r, prod_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic signed [pced_pkg::OutW-1:0] out_r, out_nxt;

  logic [15:0]        old_v;
  logic [15:0]        goal_v;
  logic signed [16:0] lam;
  logic signed [5:0]  d;
  logic               en;
  logic               is_area;
  logic signed [16:0] e;
  logic signed [17:0] e2;
  logic signed [18:0] lin;
  logic signed [41:0] q;
  logic signed [pced_pkg::OutW-1:0] term;
  logic signed [14:0] adh_diff;
  logic               out_free;

  always_comb begin
    unique case (k_r)
      K_SRC_AREA: begin
        old_v   = job_r.src.area;
        goal_v  = cfg.area_goal[16*job_r.src.ctype +: 16];
        lam     = $signed({9'b0, cfg.area_w[8*job_r.src.ctype +: 8]});
        d       = 6'sd1;
        en      = job_r.src.id != '0;
        is_area = 1'b1;
      end
      K_TGT_AREA: begin
        old_v   = job_r.tgt.area;
        goal_v  = cfg.area_goal[16*job_r.tgt.ctype +: 16];
        lam     = $signed({9'b0, cfg.area_w[8*job_r.tgt.ctype +: 8]});
        d       = -6'sd1;
        en      = job_r.tgt.id != '0;
        is_area = 1'b1;
      end
      K_SRC_PERIM: begin
        old_v   = job_r.src.perim;
        goal_v  = cfg.perim_goal[16*job_r.src.ctype +: 16];
        lam     = $signed({1'b0, cfg.perim_w[16*job_r.src.ctype +: 16]});
        d       = $signed({1'b0, job_r.src_diff}) - $signed({1'b0, job_r.src_same});
        en      = cfg.perim_on && job_r.src.id != '0;
        is_area = 1'b0;
      end
      K_TGT_PERIM: begin
        old_v   = job_r.tgt.perim;
        goal_v  = cfg.perim_goal[16*job_r.tgt.ctype +: 16];
        lam     = $signed({1'b0, cfg.perim_w[16*job_r.tgt.ctype +: 16]});
        d       = $signed({1'b0, job_r.tgt_same}) - $signed({1'b0, job_r.tgt_diff});
        en      = cfg.perim_on && job_r.tgt.id != '0;
        is_area = 1'b0;
      end
      default: begin
        old_v   = '0;
        goal_v  = '0;
        lam     = '0;
        d       = '0;
        en      = 1'b0;
        is_area = 1'b0;
      end
    endcase
  end

  // lambda * d * (2 * (old - goal) + d)
  assign e        = $signed({1'b0, old_v}) - $signed({1'b0, goal_v});
  assign e2       = {e, 1'b0};
  assign lin      = 19'(e2) + 19'(d);
  assign q        = lam * prod_r;
  assign term     = is_area ? (pced_pkg::OutW'(q) <<< 8) : pced_pkg::OutW'(q);
  assign adh_diff = $signed({1'b0, q_job.adh_after}) - $signed({1'b0, q_job.adh_before});
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    job_nxt       = job_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          job_nxt   = q_job;
          acc_nxt   = pced_pkg::OutW'(adh_diff) <<< 8;
          k_nxt     = K_SRC_AREA;
          state_nxt = ST_PROD;
        end
      end
      ST_PROD: begin
        prod_nxt  = d * lin;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (en) begin
          acc_nxt = acc_r + term;
        end
        if (k_r == K_TGT_PERIM) begin
          state_nxt = ST_FIN;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = ST_PROD;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_nxt       = acc_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_energy_delta = out_r;

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    out_r  <= out_nxt;
    k_r    <= k_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> design/potts_copy_energy_delta.sv
// ----------------------------------------------------------------------------
// potts_copy_energy_delta
// energy change of one cellular potts copy attempt: adhesion, area and
// perimeter terms, with an apb register file for the energy parameters
// ----------------------------------------------------------------------------
// throughput: one header or neighbor word per cycle at the input while the job queue is not full
// the back sequencer takes one attempt at a time: a load step, 4 terms of 2 steps each
// (product, accumulate) and a finish step; a two-entry queue absorbs short bursts
// the result word is held in an output register until the receiver takes it
// reset: synchronous active low, clears registers, held cells and sums
// ----------------------------------------------------------------------------
module potts_copy_energy_delta #(
  parameter int TYPES = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pced_pkg::AddrW-1:0]      paddr,
  input  logic [pced_pkg::DataW-1:0]      pwdata,
  output logic [pced_pkg::DataW-1:0]      prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_op,
  input  logic [pced_pkg::IdW-1:0]        in_source_id,
  input  logic [pced_pkg::TypeW-1:0]      in_source_type,
  input  logic [pced_pkg::AreaW-1:0]      in_source_area,
  input  logic [pced_pkg::PerimW-1:0]     in_source_perimeter,
  input  logic [pced_pkg::IdW-1:0]        in_target_id,
  input  logic [pced_pkg::TypeW-1:0]      in_target_type,
  input  logic [pced_pkg::AreaW-1:0]      in_target_area,
  input  logic [pced_pkg::PerimW-1:0]     in_target_perimeter,
  input  logic [pced_pkg::IdW-1:0]        in_neighbor_id,
  input  logic [pced_pkg::TypeW-1:0]      in_neighbor_type,
  input  logic                            in_last_neighbor,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [pced_pkg::OutW-1:0] out_energy_delta
);

  pced_pkg::cfg_t  cfg_r, cfg_nxt;
  logic [2:0]      reg_idx;
  logic            wr_en;
  logic            q_push;
  logic            q_full;
  pced_pkg::job_t  wr_job;
  pced_pkg::job_t  rd_job;
  logic            q_pop;
  logic            q_empty;

  assign pready  = 1'b1;
  assign reg_idx = paddr[pced_pkg::AddrW-1:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        pced_pkg::REG_ADH_LO:     cfg_nxt.adh_lo     = pwdata;
        pced_pkg::REG_ADH_HI:     cfg_nxt.adh_hi     = pwdata;
        pced_pkg::REG_AREA_W:     cfg_nxt.area_w     = pwdata[31:0];
        pced_pkg::REG_AREA_GOAL:  cfg_nxt.area_goal  = pwdata;
        pced_pkg::REG_PERIM_W:    cfg_nxt.perim_w    = pwdata;
        pced_pkg::REG_PERIM_GOAL: cfg_nxt.perim_goal = pwdata;
        pced_pkg::REG_PERIM_ON:   cfg_nxt.perim_on   = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pced_pkg::REG_ADH_LO:     prdata = cfg_r.adh_lo;
      pced_pkg::REG_ADH_HI:     prdata = cfg_r.adh_hi;
      pced_pkg::REG_AREA_W:     prdata = {32'b0, cfg_r.area_w};
      pced_pkg::REG_AREA_GOAL:  prdata = cfg_r.area_goal;
      pced_pkg::REG_PERIM_W:    prdata = cfg_r.perim_w;
      pced_pkg::REG_PERIM_GOAL: prdata = cfg_r.perim_goal;
      pced_pkg::REG_PERIM_ON:   prdata = {63'b0, cfg_r.perim_on};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pced_front #(
    .TYPES(TYPES)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_source_id       (in_source_id),
    .in_source_type     (in_source_type),
    .in_source_area     (in_source_area),
    .in_source_perimeter(in_source_perimeter),
    .in_target_id       (in_target_id),
    .in_target_type     (in_target_type),
    .in_target_area     (in_target_area),
    .in_target_perimeter(in_target_perimeter),
    .in_neighbor_id     (in_neighbor_id),
    .in_neighbor_type   (in_neighbor_type),
    .in_last_neighbor   (in_last_neighbor),
    .adh_lo             (cfg_r.adh_lo),
    .adh_hi             (cfg_r.adh_hi),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_job              (wr_job)
  );

  pced_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wr_job(wr_job),
    .pop   (q_pop),
    .rd_job(rd_job),
    .full  (q_full),
    .empty (q_empty)
  );

  pced_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_job           (rd_job),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_energy_delta(out_energy_delta)
  );

endmodule

>>> sim/potts_copy_energy_delta_test.sv
// ----------------------------------------------------------------------------
// potts_copy_energy_delta_test
// drives headers and neighbor words into the copy energy block, predicts each
// energy delta from a local model of the accumulators and terms, and checks
// every result word in order under several register settings and idle mixes
// ----------------------------------------------------------------------------
module potts_copy_energy_delta_test;
  import pced_pkg::*;

  localparam int TYPES      = 4;
  localparam int HOLD_LEN   = 400;
  localparam int TAIL_WAIT  = 24;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    logic                op;
    cell_t               src;
    cell_t               tgt;
    logic [IdW-1:0]      nbr_id;
    logic [TypeW-1:0]    nbr_type;
    logic                is_last;
  } word_t;

  logic clk;
  logic rst_n = 1'b0;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [AddrW-1:0]  paddr   = '0;
  logic [DataW-1:0]  pwdata  = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  logic               in_valid            = 1'b0;
  logic               in_ready;
  logic               in_op               = 1'b0;
  logic [IdW-1:0]     in_source_id        = '0;
  logic [TypeW-1:0]   in_source_type      = '0;
  logic [AreaW-1:0]   in_source_area      = '0;
  logic [PerimW-1:0]  in_source_perimeter = '0;
  logic [IdW-1:0]     in_target_id        = '0;
  logic [TypeW-1:0]   in_target_type      = '0;
  logic [AreaW-1:0]   in_target_area      = '0;
  logic [PerimW-1:0]  in_target_perimeter = '0;
  logic [IdW-1:0]     in_neighbor_id      = '0;
  logic [TypeW-1:0]   in_neighbor_type    = '0;
  logic               in_last_neighbor    = 1'b0;
  logic               out_valid;
  logic               out_ready           = 1'b0;
  logic signed [OutW-1:0] out_energy_delta;

  potts_copy_energy_delta #(.TYPES(TYPES)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_source_id        (in_source_id),
    .in_source_type      (in_source_type),
    .in_source_area      (in_source_area),
    .in_source_perimeter (in_source_perimeter),
    .in_target_id        (in_target_id),
    .in_target_type      (in_target_type),
    .in_target_area      (in_target_area),
    .in_target_perimeter (in_target_perimeter),
    .in_neighbor_id      (in_neighbor_id),
    .in_neighbor_type    (in_neighbor_type),
    .in_last_neighbor    (in_last_neighbor),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_energy_delta    (out_energy_delta)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // stimulus and expectation stores
  word_t           pending_words[$];
  logic [OutW-1:0] energy_due[$];
  word_t           on_bus;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              fault_count   = 0;
  int              cycle_count   = 0;
  logic            hold_ask      = 1'b0;
  logic            hold_ack      = 1'b0;
  int              hold_left     = 0;
  logic [IdW-1:0]  gen_sid       = '0;
  logic [IdW-1:0]  gen_tid       = '0;

  // local copy of the block state
  cfg_t            regs_now      = '0;
  cell_t           held_src      = '0;
  cell_t           held_tgt      = '0;
  logic [AdhW-1:0] adh_before_sum = '0;
  logic [AdhW-1:0] adh_after_sum  = '0;
  logic [CntW-1:0] src_same_n    = '0;
  logic [CntW-1:0] src_diff_n    = '0;
  logic [CntW-1:0] tgt_same_n    = '0;
  logic [CntW-1:0] tgt_diff_n    = '0;

  function automatic logic [7:0] adh_entry(logic [TypeW-1:0] ntype, logic [TypeW-1:0] ctype);
    int k;
    k = (int'(ntype) * TYPES + int'(ctype)) & 15;
    if (k < 8) return regs_now.adh_lo[8*k +: 8];
    return regs_now.adh_hi[8*(k-8) +: 8];
  endfunction

  function automatic logic [AdhW-1:0] sat_sum(logic [AdhW-1:0] acc, logic [7:0] v);
    logic [AdhW:0] s;
    s = {1'b0, acc} + v;
    return (s > ADH_MAX) ? ADH_MAX : s[AdhW-1:0];
  endfunction

  function automatic logic [CntW-1:0] bump(logic [CntW-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic longint quad_term(longint lam, longint old, longint goal, longint d);
    longint e;
    e = old - goal;
    return lam * d * (2 * e + d);
  endfunction

  task automatic clear_sums();
    adh_before_sum = '0;
    adh_after_sum  = '0;
    src_same_n     = '0;
    src_diff_n     = '0;
    tgt_same_n     = '0;
    tgt_diff_n     = '0;
  endtask

  task automatic update_energy(input word_t w);
    longint total;
    longint a;
    longint b;
    longint same;
    longint diff;
    if (w.op == OP_HEADER) begin
      held_src = w.src;
      held_tgt = w.tgt;
      clear_sums();
      return;
    end
    if (w.nbr_id != held_tgt.id)
      adh_before_sum = sat_sum(adh_before_sum, adh_entry(w.nbr_type, held_tgt.ctype));
    if (w.nbr_id != held_src.id)
      adh_after_sum = sat_sum(adh_after_sum, adh_entry(w.nbr_type, held_src.ctype));
    if (w.nbr_id == held_src.id) src_same_n = bump(src_same_n);
    else src_diff_n = bump(src_diff_n);
    if (w.nbr_id == held_tgt.id) tgt_same_n = bump(tgt_same_n);
    else tgt_diff_n = bump(tgt_diff_n);
    if (!w.is_last) return;

    a = adh_after_sum;
    b = adh_before_sum;
    total = (a - b) * 256;
    if (held_src.id != 0)
      total += 256 * quad_term(regs_now.area_w[8*held_src.ctype +: 8], held_src.area,
                               regs_now.area_goal[16*held_src.ctype +: 16], 1);
    if (held_tgt.id != 0)
      total += 256 * quad_term(regs_now.area_w[8*held_tgt.ctype +: 8], held_tgt.area,
                               regs_now.area_goal[16*held_tgt.ctype +: 16], -1);
    if (regs_now.perim_on) begin
      if (held_src.id != 0) begin
        same = src_same_n;
        diff = src_diff_n;
        total += quad_term(regs_now.perim_w[16*held_src.ctype +: 16], held_src.perim,
                           regs_now.perim_goal[16*held_src.ctype +: 16], diff - same);
      end
      if (held_tgt.id != 0) begin
        same = tgt_same_n;
        diff = tgt_diff_n;
        total += quad_term(regs_now.perim_w[16*held_tgt.ctype +: 16], held_tgt.perim,
                           regs_now.perim_goal[16*held_tgt.ctype +: 16], same - diff);
      end
    end
    energy_due.push_back(total[OutW-1:0]);
    clear_sums();
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) update_energy(on_bus);
      if (!in_valid || in_ready) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = pending_words.pop_front();
          in_op               <= on_bus.op;
          in_source_id        <= on_bus.src.id;
          in_source_type      <= on_bus.src.ctype;
          in_source_area      <= on_bus.src.area;
          in_source_perimeter <= on_bus.src.perim;
          in_target_id        <= on_bus.tgt.id;
          in_target_type      <= on_bus.tgt.ctype;
          in_target_area      <= on_bus.tgt.area;
          in_target_perimeter <= on_bus.tgt.perim;
          in_neighbor_id      <= on_bus.nbr_id;
          in_neighbor_type    <= on_bus.nbr_type;
          in_last_neighbor    <= on_bus.is_last;
          in_valid            <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold counter
  always @(posedge clk) begin
    if (hold_ask != hold_ack) begin
      hold_ack  <= hold_ask;
      hold_left <= HOLD_LEN;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    logic [OutW-1:0] exp_delta;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (energy_due.size() == 0) begin
          $display("%0t energy_delta word with none expected: expected none actual %0d",
                   $time, out_energy_delta);
          fault_count++;
        end else begin
          exp_delta = energy_due.pop_front();
          if (out_energy_delta !== exp_delta) begin
            $display("%0t energy_delta mismatch: expected %0d actual %0d",
                     $time, $signed(exp_delta), out_energy_delta);
            fault_count++;
          end
        end
      end
      if (hold_ask != hold_ack || hold_left > 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t timeout with %0d words still expected", $time, energy_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [DataW-1:0] value);
    logic [DataW-1:0] kept;
    case (idx)
      REG_AREA_W:   kept = {32'b0, value[31:0]};
      REG_PERIM_ON: kept = {63'b0, value[0]};
      default:      kept = value;
    endcase
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== kept) begin
      $display("%0t register %0d readback: expected %h actual %h", $time, idx, kept, prdata);
      fault_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_ADH_LO:     regs_now.adh_lo     = value;
      REG_ADH_HI:     regs_now.adh_hi     = value;
      REG_AREA_W:     regs_now.area_w     = value[31:0];
      REG_AREA_GOAL:  regs_now.area_goal  = value;
      REG_PERIM_W:    regs_now.perim_w    = value;
      REG_PERIM_GOAL: regs_now.perim_goal = value;
      REG_PERIM_ON:   regs_now.perim_on   = value[0];
      default: ;
    endcase
  endtask

  task automatic load_regs(input cfg_t c);
    reg_write(REG_ADH_LO, c.adh_lo);
    reg_write(REG_ADH_HI, c.adh_hi);
    reg_write(REG_AREA_W, {32'b0, c.area_w});
    reg_write(REG_AREA_GOAL, c.area_goal);
    reg_write(REG_PERIM_W, c.perim_w);
    reg_write(REG_PERIM_GOAL, c.perim_goal);
    reg_write(REG_PERIM_ON, {63'b0, c.perim_on});
  endtask

  function automatic cfg_t rand_cfg(logic on);
    cfg_t c;
    c.adh_lo     = {$urandom, $urandom};
    c.adh_hi     = {$urandom, $urandom};
    c.area_w     = $urandom;
    c.area_goal  = {$urandom, $urandom};
    c.perim_w    = {$urandom, $urandom};
    c.perim_goal = {$urandom, $urandom};
    c.perim_on   = on;
    return c;
  endfunction

  function automatic word_t noise_word();
    word_t w;
    w.op       = 1'($urandom_range(1));
    w.src      = cell_t'({$urandom, $urandom});
    w.tgt      = cell_t'({$urandom, $urandom});
    w.nbr_id   = 16'($urandom);
    w.nbr_type = 2'($urandom_range(3));
    w.is_last  = 1'($urandom_range(1));
    return w;
  endfunction

  task automatic add_header(input logic [IdW-1:0] sid, input logic [TypeW-1:0] st,
                            input logic [AreaW-1:0] sa, input logic [PerimW-1:0] sp,
                            input logic [IdW-1:0] tid, input logic [TypeW-1:0] tt,
                            input logic [AreaW-1:0] ta, input logic [PerimW-1:0] tp);
    word_t w;
    w = noise_word();
    w.op  = OP_HEADER;
    w.src = '{id: sid, ctype: st, area: sa, perim: sp};
    w.tgt = '{id: tid, ctype: tt, area: ta, perim: tp};
    pending_words.push_back(w);
    gen_sid = sid;
    gen_tid = tid;
  endtask

  task automatic add_neighbor(input logic [IdW-1:0] nid, input logic [TypeW-1:0] nt,
                              input logic fin);
    word_t w;
    w = noise_word();
    w.op       = OP_NEIGHBOR;
    w.nbr_id   = nid;
    w.nbr_type = nt;
    w.is_last  = fin;
    pending_words.push_back(w);
  endtask

  function automatic logic [IdW-1:0] pick_id();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r < 5) return 16'($urandom_range(1, 3));
    if (r == 5) return '1;
    return 16'($urandom);
  endfunction

  // values close to the goal make the quadratic terms small and sign-varying
  function automatic logic [15:0] near(logic [15:0] goal);
    int r;
    r = $urandom_range(9);
    if (r < 3) return 16'(goal + $urandom_range(0, 6) - 3);
    if (r == 3) return '0;
    if (r == 4) return '1;
    return 16'($urandom);
  endfunction

  task automatic gen_attempts(input int budget, input bit brief);
    int added;
    int pick;
    int n;
    int r;
    logic [TypeW-1:0] st;
    logic [TypeW-1:0] tt;
    logic [IdW-1:0]   nid;
    added = 0;
    while (added < budget) begin
      pick = $urandom_range(99);
      // mostly full attempts, some continuing on held cells, some stray headers
      if (pick >= 8) begin
        if (pick < 14) begin
          add_header(16'($urandom), 2'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 2'($urandom), 16'($urandom), 16'($urandom));
          added++;
        end
        st = 2'($urandom_range(3));
        tt = 2'($urandom_range(3));
        add_header(pick_id(), st, near(regs_now.area_goal[16*st +: 16]),
                   near(regs_now.perim_goal[16*st +: 16]),
                   pick_id(), tt, near(regs_now.area_goal[16*tt +: 16]),
                   near(regs_now.perim_goal[16*tt +: 16]));
        added++;
      end
      r = $urandom_range(99);
      if (brief) n = $urandom_range(1, 2);
      else if (r < 80) n = $urandom_range(1, 8);
      else if (r < 95) n = $urandom_range(9, 26);
      else n = $urandom_range(32, 70);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(9);
        if (r < 3) nid = gen_sid;
        else if (r < 6) nid = gen_tid;
        else if (r == 6) nid = '0;
        else if (r == 7) nid = 16'($urandom_range(1, 3));
        else nid = 16'($urandom);
        add_neighbor(nid, 2'($urandom_range(3)), i == n - 1);
        added++;
      end
    end
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_words.size() > 0 || in_valid || energy_due.size() > 0);
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  task automatic run_phase(input cfg_t c, input int send_pct, input int recv_pct,
                           input int budget);
    load_regs(c);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    gen_attempts(budget, 1'b0);
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_regs(rand_cfg(1'b1));
    // neighbors ahead of any header use the zeroed held cells
    add_neighbor(16'd5, 2'd1, 1'b0);
    add_neighbor(16'd0, 2'd3, 1'b1);
    // widest ids, areas and perimeters, empty target area
    add_header('1, 2'd3, '1, '1, '1, 2'd3, '0, '0);
    add_neighbor('1, 2'd3, 1'b0);
    add_neighbor('0, 2'd0, 1'b1);
    // medium target, then a second header replacing it with a medium source
    add_header('0, 2'd0, '0, '0, 16'd1, 2'd2, 16'd100, 16'd20);
    add_header(16'd2, 2'd1, 16'd50, 16'd30, '0, 2'd0, 16'd40, 16'd10);
    add_neighbor(16'd2, 2'd1, 1'b0);
    add_neighbor(16'd7, 2'd2, 1'b0);
    add_neighbor('0, 2'd0, 1'b1);
    // new sum on the same held cells
    add_neighbor(16'd2, 2'd3, 1'b1);
    add_header(16'd3, 2'd0, 16'd1, 16'd4, 16'd4, 2'd1, 16'd1, 16'd4);
    add_neighbor(16'd3, 2'd2, 1'b0);
    add_neighbor(16'd4, 2'd1, 1'b0);
    add_neighbor(16'd4, 2'd3, 1'b0);
    add_neighbor(16'd9, 2'd0, 1'b1);
    drain();

    run_phase('1, 0, 0, 180);
    run_phase('0, 47, 0, 180);
    run_phase(rand_cfg(1'b1), 0, 47, 180);
    run_phase(rand_cfg(1'b0), 9, 9, 180);

    // long receiver hold while short attempts keep coming
    load_regs(rand_cfg(1'b1));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_ask <= ~hold_ask;
    gen_attempts(60, 1'b1);
    drain();
    send_idle_pct = 9;
    recv_idle_pct = 9;
    gen_attempts(90, 1'b0);
    drain();

    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
design/pced_pkg.sv
design/pced_front.sv
design/pced_queue.sv
design/pced_back.sv
design/potts_copy_energy_delta.sv
sim/potts_copy_energy_delta_test.sv
